// ----- design/tccw_pkg.sv -----
// Package: constants and types of the text console cursor writer.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned TAB_SPACES = 4;

  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned TABC_W  = 4;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [TABC_W-1:0] TAB_REST   = TABC_W'(TAB_SPACES - 1);

  typedef enum logic {
    KIND_PUT   = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

endpackage : tccw_pkg

`default_nettype wire

// ----- design/text_console_cursor_writer.sv -----
// Top level: character writer of a text console, cursor tracking and cell writes.
// An accepted transaction's first result is in the output register in the cycle after it is accepted.
// Throughput: one transaction per cycle for printed bytes, newlines and clears; a tab
// produces TAB_SPACES results one after another and stalls input until the last one.
// The output register frees each cycle its result is taken, so input keeps flowing then.
// Reset (rst_ni low, asynchronous): cursor homed to cell 0, no tab pending, output empty.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_writer import tccw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              kind_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   cell_write_o,
  output logic [ADDR_W-1:0]      cell_address_o,
  output logic [CHAR_W-1:0]      cell_char_o,
  output logic [ADDR_W-1:0]      cursor_position_o,
  output logic                   clear_screen_o,
  output logic                   last_o
);

  // Cursor state. base_q tracks row_q*COLUMNS (mod 2^ADDR_W) so that no multiplier
  // is needed; the linear position is base_q + col_q.
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] base_q, base_d;

  // Spaces of a tab still to be written after the first.
  logic [TABC_W-1:0] tab_cnt_q, tab_cnt_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              wr_q, wr_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              clr_q, clr_d;
  logic              last_q, last_d;

  logic out_free;    // output register can take a new result this cycle
  logic in_acc;      // input transaction accepted
  logic tab_busy;

  // Shared cursor arithmetic.
  logic              wrap;
  logic              at_bottom;
  logic [ROW_W-1:0]  nl_row;
  logic [ADDR_W-1:0] nl_base;
  logic [ADDR_W-1:0] pos_now;

  // Print step helpers.
  logic              do_print;
  logic [CHAR_W-1:0] print_char;
  logic              print_last;

  assign tab_busy   = (tab_cnt_q != '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = tab_busy || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign wrap      = (col_q == COL_LAST);
  assign at_bottom = (row_q == ROW_LAST);
  assign nl_row    = at_bottom ? row_q : row_q + ROW_W'(1);
  // bottom row holds; no scrolling
  assign nl_base   = at_bottom ? base_q : base_q + ROW_STRIDE;
  assign pos_now   = base_q + ADDR_W'(col_q);

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    base_d      = base_q;
    tab_cnt_d   = tab_cnt_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    wr_d        = wr_q;
    addr_d      = addr_q;
    char_d      = char_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    last_d      = last_q;
    do_print    = 1'b0;
    print_char  = CH_SPACE;
    print_last  = 1'b1;

    if (tab_busy) begin
      if (out_free) begin
        // remaining spaces of a tab, one per cycle while the output register is free
        do_print   = 1'b1;
        print_last = (tab_cnt_q == TABC_W'(1));
        tab_cnt_d  = tab_cnt_q - TABC_W'(1);
      end
    end else if (in_acc) begin
      priority if (kind_e'(kind_i) == KIND_CLEAR) begin
        col_d       = '0;
        row_d       = '0;
        base_d      = '0;
        out_valid_d = 1'b1;
        wr_d        = 1'b0;
        addr_d      = '0;
        char_d      = '0;
        pos_d       = '0;
        clr_d       = 1'b1;
        last_d      = 1'b1;
      end else if (char_code_i == CH_NEWLINE) begin
        col_d       = '0;
        row_d       = nl_row;
        base_d      = nl_base;
        out_valid_d = 1'b1;
        wr_d        = 1'b0;
        addr_d      = '0;
        char_d      = '0;
        pos_d       = nl_base;
        clr_d       = 1'b0;
        last_d      = 1'b1;
      end else if (char_code_i == CH_TAB) begin
        do_print   = 1'b1;
        print_last = (TAB_REST == '0);
        tab_cnt_d  = TAB_REST;
      end else begin
        do_print   = 1'b1;
        print_char = char_code_i;
        print_last = 1'b1;
      end
    end

    if (do_print) begin
      // store at the cursor, then advance with wrap to the next row
      col_d       = wrap ? '0 : col_q + COL_W'(1);
      row_d       = wrap ? nl_row : row_q;
      base_d      = wrap ? nl_base : base_q;
      out_valid_d = 1'b1;
      wr_d        = 1'b1;
      addr_d      = pos_now;
      char_d      = print_char;
      pos_d       = wrap ? nl_base : pos_now + ADDR_W'(1);
      clr_d       = 1'b0;
      last_d      = print_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      tab_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      tab_cnt_q   <= tab_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q   <= wr_d;
    addr_q <= addr_d;
    char_q <= char_d;
    pos_q  <= pos_d;
    clr_q  <= clr_d;
    last_q <= last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign cell_write_o      = wr_q;
  assign cell_address_o    = addr_q;
  assign cell_char_o       = char_q;
  assign cursor_position_o = pos_q;
  assign clear_screen_o    = clr_q;
  assign last_o            = last_q;

`ifndef ASSERT_OFF
  // a pending tab always blocks new input
  a_tab_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_busy |-> in_stall_o)
    else $error("input not stalled during tab expansion");

  // a pending tab always has a space result in the output register
  a_tab_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_busy |-> out_valid_q)
    else $error("tab pending without output");

  // cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_LAST) && (row_q <= ROW_LAST))
    else $error("cursor out of range");

  // a clear result homes the cursor and writes no cell
  a_clear_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && clr_q) |-> (pos_q == '0 && !wr_q && last_q))
    else $error("clear result malformed");
`endif

endmodule : text_console_cursor_writer

`default_nettype wire
